>>> hw/rtl/mfd_pkg.sv
// shared types, constants and rounding function of the multitap feedback delay
// no dependencies
package mfd_pkg;

  localparam int BUF_DEPTH  = 4096;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int MAX_TAPS   = 4;
  localparam int TAP_REGS   = 4;
  localparam int TAP_IDX_W  = $clog2(TAP_REGS + 1);
  localparam int TAP_SEL_W  = $clog2(TAP_REGS);
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 12;
  localparam int COUNT_W    = 3;
  localparam int ACC_W      = 34;
  localparam int MUL_CNT_W  = $clog2(GAIN_W);
  localparam int FRAC_SHIFT = 14;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  localparam logic signed [GAIN_W-1:0] TAP_GAIN = 16'sd2458;

  typedef enum logic [2:0] {
    REG_BUFFER_LENGTH = 3'd0,
    REG_TAP_COUNT     = 3'd1,
    REG_INPUT_GAIN    = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_TAP_DELAY_0   = 3'd4,
    REG_TAP_DELAY_1   = 3'd5,
    REG_TAP_DELAY_2   = 3'd6,
    REG_TAP_DELAY_3   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GAIN,
    ST_TAP_RD,
    ST_TAP_WAIT,
    ST_TAP_MAC,
    ST_FB,
    ST_FB_MAC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]                   buffer_length;
    logic [COUNT_W-1:0]                 tap_count;
    logic signed [GAIN_W-1:0]           input_gain;
    logic signed [GAIN_W-1:0]           feedback_gain;
    logic [TAP_REGS-1:0][DELAY_W-1:0]   tap_delay;
  } cfg_t;

  typedef struct packed {
    logic                      start;
    logic                      load;
    logic signed [ACC_W-1:0]   load_value;
    logic signed [GAIN_W-1:0]  mcand;
    logic signed [SAMPLE_W-1:0] mplier;
  } mac_cmd_t;

  // floor((acc + half) / 2^14), saturated to a sample
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-FRAC_SHIFT-1:0] q;
    biased = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
    q = biased[ACC_W-1:FRAC_SHIFT];
    if (q > (ACC_W-FRAC_SHIFT)'(32767)) begin
      round_sat = 16'sh7fff;
    end else if (q < -(ACC_W-FRAC_SHIFT)'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = q[SAMPLE_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/multitap_feedback_delay.sv
// top level of the multitap feedback delay: sequencer, delay store, output register
// depends on mfd_pkg, mfd_regs, mfd_serial_mac, mfd_ram
//
// One signed Q1.15 sample enters per beat and one saturated Q1.15 sample leaves
// for it. Each sample is worked through a single bit-serial multiply-accumulate
// unit that works one product at a time in 16 bit steps: the direct gain product,
// then one product per active tap (each after a read of the delay store), then the
// feedback product. The result waits in an output register, so the next sample is
// taken while an earlier one is still stalled at the output. After reset a clearing
// pass writes zero to all 4096 delay entries, one a cycle, and no sample is taken
// during that pass; register writes are taken throughout.
// Registers sit on the apb port at byte address 4 * index.
module multitap_feedback_delay import mfd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // sample in
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  // sample out
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  cfg_t     cfg;
  mac_cmd_t mac_cmd;
  logic     mac_busy;
  logic signed [ACC_W-1:0] acc;

  state_t state, state_next;

  // per-item registers
  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] y;
  logic [ADDR_W-1:0]          wp;
  logic [LEN_W-1:0]           len;
  logic [TAP_IDX_W-1:0]       taps;
  logic [TAP_IDX_W-1:0]       tap_idx;
  logic [ADDR_W-1:0]          clr_addr;

  // ram port
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [SAMPLE_W-1:0]  ram_wdata;
  logic [SAMPLE_W-1:0]  ram_rdata;

  logic                 in_accept;
  logic                 out_take;
  logic                 out_load;

  // clamped configuration seen at accept time
  logic [LEN_W-1:0]     len_clamp;
  logic [TAP_IDX_W-1:0] taps_clamp;
  logic [LEN_W-1:0]     wp_inc;
  logic [ADDR_W-1:0]    wp_adv;

  // read position of the current tap
  logic [LEN_W-1:0]     tap_d;
  logic [LEN_W-1:0]     wp_ext;
  logic [LEN_W-1:0]     rp;

  logic signed [SAMPLE_W-1:0] y_new;
  logic signed [SAMPLE_W-1:0] stored;

  mfd_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mfd_serial_mac u_mac (
    .clk, .rst, .cmd(mac_cmd), .busy(mac_busy), .acc
  );

  mfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(BUF_DEPTH)) u_store (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    if (cfg.buffer_length < LEN_W'(2)) begin
      len_clamp = LEN_W'(2);
    end else if (cfg.buffer_length > LEN_W'(BUF_DEPTH)) begin
      len_clamp = LEN_W'(BUF_DEPTH);
    end else begin
      len_clamp = cfg.buffer_length;
    end
    if (cfg.tap_count > COUNT_W'(MAX_TAPS)) begin
      taps_clamp = TAP_IDX_W'(MAX_TAPS);
    end else begin
      taps_clamp = TAP_IDX_W'(cfg.tap_count);
    end
    // wrap at or past the length in use, also after a shortened buffer
    wp_inc = LEN_W'(wp) + LEN_W'(1);
    wp_adv = (wp_inc >= len_clamp) ? '0 : wp_inc[ADDR_W-1:0];
  end

  always_comb begin
    tap_d  = LEN_W'(cfg.tap_delay[tap_idx[TAP_SEL_W-1:0]]);
    if (tap_d >= len) tap_d = len - LEN_W'(1);
    wp_ext = LEN_W'(wp);
    rp     = (wp_ext >= tap_d) ? wp_ext - tap_d : wp_ext + len - tap_d;
  end

  assign y_new  = round_sat(acc);
  assign stored = round_sat(acc);

  // output register frees up when the old beat leaves
  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    in_stall           = 1'b1;
    mac_cmd.start      = 1'b0;
    mac_cmd.load       = 1'b0;
    mac_cmd.load_value = '0;
    mac_cmd.mcand      = cfg.input_gain;
    mac_cmd.mplier     = sample_in;
    ram_we             = 1'b0;
    ram_addr           = rp[ADDR_W-1:0];
    ram_wdata          = '0;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
        if (clr_addr == ADDR_W'(BUF_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // direct path product starts from a cleared sum
          mac_cmd.start = 1'b1;
          mac_cmd.load  = 1'b1;
          state_next    = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (!mac_busy) state_next = ST_TAP_RD;
      end
      ST_TAP_RD: begin
        state_next = (tap_idx == taps) ? ST_FB : ST_TAP_WAIT;
      end
      ST_TAP_WAIT: begin
        mac_cmd.start  = 1'b1;
        mac_cmd.mcand  = TAP_GAIN;
        mac_cmd.mplier = ram_rdata;
        state_next     = ST_TAP_MAC;
      end
      ST_TAP_MAC: begin
        if (!mac_busy) state_next = ST_TAP_RD;
      end
      ST_FB: begin
        // sum restarts from the dry sample at full scale
        mac_cmd.start      = 1'b1;
        mac_cmd.load       = 1'b1;
        mac_cmd.load_value = ACC_W'(x) <<< FRAC_SHIFT;
        mac_cmd.mcand      = cfg.feedback_gain;
        mac_cmd.mplier     = y_new;
        state_next         = ST_FB_MAC;
      end
      ST_FB_MAC: begin
        if (!mac_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        ram_addr  = wp;
        ram_wdata = stored;
        if (out_load) begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      clr_addr <= '0;
      tap_idx  <= '0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (in_accept) begin
        wp      <= wp_adv;
        tap_idx <= '0;
      end else if (state == ST_TAP_MAC && !mac_busy) begin
        tap_idx <= tap_idx + TAP_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x    <= sample_in;
      len  <= len_clamp;
      taps <= taps_clamp;
    end
    if (state == ST_FB) y <= y_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) sample_out <= y;
  end

  // no sample taken while the store is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("sample taken during clearing pass");

  // the serial unit is never restarted while a product is in flight
  a_mac_free: assert property (@(posedge clk) disable iff (rst)
    mac_cmd.start |-> !mac_busy)
    else $error("multiply restarted while busy");

  // store writes only in clearing or at the end of an item
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("unexpected delay store write");

  // a waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !out_load)
    else $error("output register overwritten");

endmodule

>>> hw/rtl/mfd_ram.sv
// generic single port ram with registered read
// no dependencies
module mfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/mfd_regs.sv
// apb register file for the delay configuration
// depends on mfd_pkg
module mfd_regs import mfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_length <= LEN_W'(BUF_DEPTH);
      cfg.tap_count     <= '0;
      cfg.input_gain    <= 16'sd16384;
      cfg.feedback_gain <= 16'sd8192;
      for (int i = 0; i < TAP_REGS; i++) cfg.tap_delay[i] <= DELAY_W'(1);
    end else if (wr) begin
      case (idx)
        REG_BUFFER_LENGTH: cfg.buffer_length <= pwdata[LEN_W-1:0];
        REG_TAP_COUNT:     cfg.tap_count     <= pwdata[COUNT_W-1:0];
        REG_INPUT_GAIN:    cfg.input_gain    <= pwdata[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: cfg.feedback_gain <= pwdata[GAIN_W-1:0];
        REG_TAP_DELAY_0:   cfg.tap_delay[0]  <= pwdata[DELAY_W-1:0];
        REG_TAP_DELAY_1:   cfg.tap_delay[1]  <= pwdata[DELAY_W-1:0];
        REG_TAP_DELAY_2:   cfg.tap_delay[2]  <= pwdata[DELAY_W-1:0];
        REG_TAP_DELAY_3:   cfg.tap_delay[3]  <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BUFFER_LENGTH: prdata = PDATA_W'(cfg.buffer_length);
      REG_TAP_COUNT:     prdata = PDATA_W'(cfg.tap_count);
      REG_INPUT_GAIN:    prdata = PDATA_W'($unsigned(cfg.input_gain));
      REG_FEEDBACK_GAIN: prdata = PDATA_W'($unsigned(cfg.feedback_gain));
      REG_TAP_DELAY_0:   prdata = PDATA_W'(cfg.tap_delay[0]);
      REG_TAP_DELAY_1:   prdata = PDATA_W'(cfg.tap_delay[1]);
      REG_TAP_DELAY_2:   prdata = PDATA_W'(cfg.tap_delay[2]);
      REG_TAP_DELAY_3:   prdata = PDATA_W'(cfg.tap_delay[3]);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/mfd_serial_mac.sv
// bit-serial signed multiply-accumulate, one multiplier bit per cycle
// depends on mfd_pkg
module mfd_serial_mac import mfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  output logic                    busy,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0]    mcand;
  logic [SAMPLE_W-1:0]        mplier;
  logic [MUL_CNT_W-1:0]       cnt;
  logic                       last;

  assign last = (cnt == MUL_CNT_W'(SAMPLE_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= cmd.load_value;
    end else if (busy && mplier[0]) begin
      // sign bit of the multiplier carries negative weight
      acc <= last ? acc - mcand : acc + mcand;
    end
    if (cmd.start) begin
      mcand  <= ACC_W'(cmd.mcand);
      mplier <= cmd.mplier;
      cnt    <= '0;
    end else if (busy) begin
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt    <= cnt + MUL_CNT_W'(1);
    end
  end

endmodule
